/* sv/cbvu_pkg.sv */
// ----------------------------------------------------------------------------
// cbvu_pkg: shared constants and types for the buoyancy velocity update
// Widths of the fixed-point datapath and the divider cell transaction format.
// ----------------------------------------------------------------------------
package cbvu_pkg;

    localparam int FRAC_BITS = 16;            // fraction bits of the velocity format

    localparam int PT_W    = 22;              // Q10.12 temperatures
    localparam int Q_W     = 16;              // Q0.16 mixing ratios
    localparam int GAIN_W  = 24;              // Q8.16 gains
    localparam int GFRAC_W = 16;              // fraction bits of the gains
    localparam int VEL_W   = 32;              // signed velocity
    localparam int CFG_IDX_W = 2;

    localparam int VF_W    = 17;              // Q1.16 virtual factor
    localparam int VFP_W   = 32;              // coefficient times qv
    localparam logic [Q_W-1:0] VF_COEF = 16'd39977;

    localparam int PROD_W  = PT_W + VF_W;     // virtual temperatures
    localparam int NUM_W   = PROD_W + FRAC_BITS + 1;
    localparam int REL_W   = PT_W + FRAC_BITS + 1;
    localparam int GP_W    = GAIN_W + Q_W + 1;
    localparam int G_SH    = 33 - FRAC_BITS;
    localparam int GQ_W    = GP_W - G_SH;
    localparam int B_W     = REL_W + 1;
    localparam int LO_W    = 24;
    localparam int HI_W    = REL_W - LO_W;
    localparam int PLO_W   = GAIN_W + LO_W;
    localparam int PHI_W   = GAIN_W + HI_W;
    localparam int DMAG_W  = REL_W + GAIN_W - GFRAC_W + 1;
    localparam int SUM_W   = DMAG_W + 2;

    localparam logic [CFG_IDX_W-1:0] REG_BUOY_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAV_GAIN = 2'd1;
    localparam logic [GAIN_W-1:0]    BUOY_RESET    = 24'd65536;
    localparam logic [GAIN_W-1:0]    GRAV_RESET    = 24'd642908;

    // one transaction as it moves along the divider chain
    typedef struct packed {
        logic [PROD_W-1:0]       rem;
        logic [NUM_W-1:0]        nq;     // dividend bits out at the top, quotient in below
        logic [PROD_W-1:0]       den;
        logic                    neg;
        logic                    zdiv;
        logic [GQ_W-1:0]         gq;
        logic signed [VEL_W-1:0] vin;
    } t_div_data;

endpackage

/* sv/cloud_buoyancy_velocity_update.sv */
// ----------------------------------------------------------------------------
// cloud_buoyancy_velocity_update: per-cell buoyancy velocity update
// Virtual temperature buoyancy, cloud-water drag and saturating velocity add.
// ----------------------------------------------------------------------------
// The block is a single pipeline that takes one grid cell per cycle while the
// output is not stalled and gives one result per cell, in order. Most of the
// pipeline is the divider: a row of NUM_W identical cells, each resolving one
// bit of |vpt - avpt| / avpt and passing its transaction to the next cell
// whenever the pipeline advances. The whole pipeline advances together; when
// the output transaction is stalled every stage holds and the input is
// stalled too. A zero ambient temperature passes the velocity through
// unchanged with zero_divisor set. Write the gain registers only while no
// transaction is in flight.
// ----------------------------------------------------------------------------
module cloud_buoyancy_velocity_update
    import cbvu_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [GAIN_W-1:0]       i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [PT_W-1:0]         i_pot_temp,
    input  logic [Q_W-1:0]          i_vapour_ratio,
    input  logic [Q_W-1:0]          i_cloud_water,
    input  logic [Q_W-1:0]          i_cloud_water_below,
    input  logic [PT_W-1:0]         i_ambient_temp,
    input  logic signed [VEL_W-1:0] i_velocity_in,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [VEL_W-1:0] o_velocity_out,
    output logic                    o_zero_divisor,
    output logic                    o_saturated
);

    localparam logic signed [SUM_W-1:0] VMAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] VMIN = -SUM_W'(64'sd2147483648);

    // gain registers
    logic [GAIN_W-1:0] r_buoy_gain;
    logic [GAIN_W-1:0] r_grav_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buoy_gain <= BUOY_RESET;
            r_grav_gain <= GRAV_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BUOY_GAIN: r_buoy_gain <= i_cfg_data;
                REG_GRAV_GAIN: r_grav_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // the whole pipeline moves when the output register is free or being taken
    logic r5_vld;
    logic adv;
    assign adv     = !(r5_vld && i_stall);
    assign o_stall = !adv;

    // stage 0: virtual factor product and cloud-water gravity product
    logic                    r0_vld;
    logic [VFP_W-1:0]        r0_vfp;
    logic [GP_W-1:0]         r0_gp;
    logic [PT_W-1:0]         r0_pt, r0_amb;
    logic signed [VEL_W-1:0] r0_vin;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r0_vfp <= VFP_W'(VF_COEF) * VFP_W'(i_vapour_ratio);
            r0_gp  <= GP_W'(r_grav_gain)
                    * GP_W'({1'b0, i_cloud_water} + {1'b0, i_cloud_water_below});
            r0_pt  <= i_pot_temp;
            r0_amb <= i_ambient_temp;
            r0_vin <= i_velocity_in;
        end
    end

    // stage 1: round the factor and the gravity product, form both virtual temperatures
    logic [VF_W-1:0]         vf;
    logic [GP_W-1:0]         gp_rnd;
    logic                    r1_vld;
    logic [PROD_W-1:0]       r1_vpt, r1_avpt;
    logic [GQ_W-1:0]         r1_gq;
    logic                    r1_zdiv;
    logic signed [VEL_W-1:0] r1_vin;

    assign vf     = VF_W'(17'h10000) + VF_W'((33'(r0_vfp) + 33'h8000) >> 16);
    assign gp_rnd = r0_gp + (GP_W'(1) << (G_SH - 1));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_vpt  <= PROD_W'(r0_pt) * PROD_W'(vf);
            r1_avpt <= PROD_W'(r0_amb) * PROD_W'(vf);
            r1_gq   <= gp_rnd[GP_W-1:G_SH];
            r1_zdiv <= (r0_amb == '0);
            r1_vin  <= r0_vin;
        end
    end

    // stage 2: magnitude of the difference, build the rounded dividend
    logic              neg2;
    logic [PROD_W-1:0] mag2;
    logic              r2_vld;
    t_div_data         r2_data;

    assign neg2 = (r1_vpt < r1_avpt);
    assign mag2 = neg2 ? (r1_avpt - r1_vpt) : (r1_vpt - r1_avpt);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_data.rem  <= '0;
            r2_data.nq   <= (NUM_W'(mag2) << FRAC_BITS) + NUM_W'(r1_avpt >> 1);
            r2_data.den  <= r1_avpt;
            r2_data.neg  <= neg2;
            r2_data.zdiv <= r1_zdiv;
            r2_data.gq   <= r1_gq;
            r2_data.vin  <= r1_vin;
        end
    end

    // divider: one cell per dividend bit
    logic      cell_vld  [NUM_W+1];
    t_div_data cell_data [NUM_W+1];

    assign cell_vld[0]  = r2_vld;
    assign cell_data[0] = r2_data;

    for (genvar g = 0; g < NUM_W; g++) begin : g_cell
        cbvu_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (adv),
            .i_vld  (cell_vld[g]),
            .i_data (cell_data[g]),
            .o_vld  (cell_vld[g+1]),
            .o_data (cell_data[g+1])
        );
    end

    t_div_data dq;
    assign dq = cell_data[NUM_W];

    // stage 3: signed relative difference minus gravity term
    logic [REL_W-1:0]        relmag;
    logic signed [B_W:0]     b3;
    logic                    r3_vld;
    logic                    r3_neg, r3_zdiv;
    logic [REL_W-1:0]        r3_bmag;
    logic signed [VEL_W-1:0] r3_vin;

    assign relmag = dq.nq[REL_W-1:0];
    assign b3 = (dq.neg ? -$signed({2'b0, relmag}) : $signed({2'b0, relmag}))
              - $signed((B_W+1)'(dq.gq));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_neg  <= b3[B_W];
            r3_bmag <= b3[B_W] ? REL_W'(-b3) : REL_W'(b3);
            r3_zdiv <= dq.zdiv;
            r3_vin  <= dq.vin;
        end
    end

    // stage 4: buoyancy gain, split into two partial products
    logic                    r4_vld;
    logic                    r4_neg, r4_zdiv;
    logic [PLO_W-1:0]        r4_plo;
    logic [PHI_W-1:0]        r4_phi;
    logic signed [VEL_W-1:0] r4_vin;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_plo  <= PLO_W'(r_buoy_gain) * PLO_W'(r3_bmag[LO_W-1:0]);
            r4_phi  <= PHI_W'(r_buoy_gain) * PHI_W'(r3_bmag[REL_W-1:LO_W]);
            r4_neg  <= r3_neg;
            r4_zdiv <= r3_zdiv;
            r4_vin  <= r3_vin;
        end
    end

    // stage 5: combine, round half up, add to velocity and saturate, or pass the velocity through on a zero divisor
    logic [DMAG_W-1:0]       dmag;
    logic signed [SUM_W-1:0] sum5;
    logic signed [VEL_W-1:0] r5_vel;
    logic                    r5_zdiv, r5_sat;

    assign dmag = (DMAG_W'(r4_phi) << (LO_W - GFRAC_W))
                + DMAG_W'((r4_plo + (PLO_W'(1) << (GFRAC_W - 1))) >> GFRAC_W);
    assign sum5 = r4_neg ? (SUM_W'(r4_vin) - $signed({2'b0, dmag}))
                         : (SUM_W'(r4_vin) + $signed({2'b0, dmag}));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_zdiv <= r4_zdiv;
            priority if (r4_zdiv) begin
                r5_vel <= r4_vin;
                r5_sat <= 1'b0;
            end else if (sum5 > VMAX) begin
                r5_vel <= VMAX[VEL_W-1:0];
                r5_sat <= 1'b1;
            end else if (sum5 < VMIN) begin
                r5_vel <= VMIN[VEL_W-1:0];
                r5_sat <= 1'b1;
            end else begin
                r5_vel <= sum5[VEL_W-1:0];
                r5_sat <= 1'b0;
            end
        end
    end

    // valid chain: advance with the payload, clear on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (adv) begin
            r0_vld <= i_valid;
            r1_vld <= r0_vld;
            r2_vld <= r1_vld;
            r3_vld <= cell_vld[NUM_W];
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    assign o_valid        = r5_vld;
    assign o_velocity_out = r5_vel;
    assign o_zero_divisor = r5_zdiv;
    assign o_saturated    = r5_sat;

    a_zdiv_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_divisor |-> !o_saturated)
        else $error("zero divisor result marked saturated");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |->
            (o_velocity_out == 32'sh7FFFFFFF) || (o_velocity_out == 32'sh80000000))
        else $error("saturated result not at a limit");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r5_vld && i_stall |-> o_stall)
        else $error("input taken while output stalled");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r0_vld)
        else $error("accepted transaction lost at entry");

endmodule

/* sv/cbvu_div_cell.sv */
// ----------------------------------------------------------------------------
// cbvu_div_cell: one restoring-division cell
// Resolves one quotient bit and hands the transaction to the next cell.
// ----------------------------------------------------------------------------
module cbvu_div_cell
    import cbvu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_vld,
    input  t_div_data i_data,
    output logic      o_vld,
    output t_div_data o_data
);

    logic      r_vld;
    t_div_data r_data;
    t_div_data n_data;
    logic [PROD_W:0] trial;
    logic            ge;

    always_comb begin
        trial  = {i_data.rem, i_data.nq[NUM_W-1]};
        ge     = (trial >= {1'b0, i_data.den});
        n_data = i_data;
        n_data.rem = ge ? PROD_W'(trial - {1'b0, i_data.den}) : trial[PROD_W-1:0];
        n_data.nq  = {i_data.nq[NUM_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

/* verif/cloud_buoyancy_velocity_update_test.sv */
// ----------------------------------------------------------------------------
// cloud_buoyancy_velocity_update_test: self-checking bench for the block
// Drives grid-cell transactions with random gaps and output stalls, predicts
// each updated velocity and its flags, and compares them in order.
// ----------------------------------------------------------------------------
module cloud_buoyancy_velocity_update_test;
    import cbvu_pkg::*;

    // Allow well beyond the depth of the pipeline.
    localparam int DRAIN_CYCLES = 3 + NUM_W + 3 + 20;
    localparam int IDLE_LIMIT   = 4000;
    localparam int MAX_GAP      = 14;

    // Register indexes with no register behind them.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic signed [VEL_W-1:0] velocity;
        logic                    zero_div;
        logic                    sat;
    } t_update;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [GAIN_W-1:0]       i_cfg_data;
    logic                    i_valid;
    logic                    o_stall;
    logic [PT_W-1:0]         i_pot_temp;
    logic [Q_W-1:0]          i_vapour_ratio;
    logic [Q_W-1:0]          i_cloud_water;
    logic [Q_W-1:0]          i_cloud_water_below;
    logic [PT_W-1:0]         i_ambient_temp;
    logic signed [VEL_W-1:0] i_velocity_in;
    logic                    o_valid;
    logic                    i_stall;
    logic signed [VEL_W-1:0] o_velocity_out;
    logic                    o_zero_divisor;
    logic                    o_saturated;

    cloud_buoyancy_velocity_update u_dut (.*);

    // Predictor copy of the gain registers.
    logic [GAIN_W-1:0] buoy_gain;
    logic [GAIN_W-1:0] grav_gain;

    t_update pending_updates[$];
    int      error_count;
    int      cells_sent;
    int      updates_seen;
    int      zero_div_seen;
    int      sat_seen;
    int      idle_cycles;
    int      stall_wait;
    bit      stall_drawn;
    bit      output_stalls_on;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Work out the updated velocity for one cell with the current gains.
    function automatic t_update predict_update(
        input logic [PT_W-1:0] pt, input logic [Q_W-1:0] qv,
        input logic [Q_W-1:0] qc, input logic [Q_W-1:0] qcb,
        input logic [PT_W-1:0] amb, input logic signed [VEL_W-1:0] vin);
        t_update           res;
        logic [63:0]       vf, vpt, avpt, mag, relmag, gq, bmag, dmag;
        logic [63:0]       plo;
        logic signed [63:0] rel, b, total;
        res.zero_div = 1'b0;
        res.sat      = 1'b0;
        if (amb == '0) begin
            res.velocity = vin;
            res.zero_div = 1'b1;
            return res;
        end
        vf   = 64'd65536 + ((64'(VF_COEF) * qv + 64'd32768) >> 16);
        vpt  = 64'(pt) * vf;
        avpt = 64'(amb) * vf;
        mag  = (vpt >= avpt) ? vpt - avpt : avpt - vpt;
        relmag = ((mag << FRAC_BITS) + (avpt >> 1)) / avpt;
        rel  = (vpt >= avpt) ? $signed(relmag) : -$signed(relmag);
        gq   = (64'(grav_gain) * (64'(qc) + 64'(qcb)) + (64'd1 << (32 - FRAC_BITS)))
               >> (33 - FRAC_BITS);
        b    = rel - $signed(gq);
        bmag = (b >= 0) ? b : -b;
        // Split the magnitude so the product stays within 64 bits.
        plo  = 64'(buoy_gain) * (bmag & 64'hFFFFFF);
        dmag = ((64'(buoy_gain) * (bmag >> 24)) << 8) + ((plo + 64'd32768) >> 16);
        total = (b >= 0) ? 64'(vin) + $signed(dmag) : 64'(vin) - $signed(dmag);
        if (total > 64'sd2147483647) begin
            total   = 64'sd2147483647;
            res.sat = 1'b1;
        end else if (total < -64'sd2147483648) begin
            total   = -64'sd2147483648;
            res.sat = 1'b1;
        end
        res.velocity = total[VEL_W-1:0];
        return res;
    endfunction

    // Send one cell: hold the transaction until the block takes it. Valid
    // stays high into the next cell when there is no gap.
    task automatic send_cell(input logic [PT_W-1:0] pt, input logic [Q_W-1:0] qv,
                             input logic [Q_W-1:0] qc, input logic [Q_W-1:0] qcb,
                             input logic [PT_W-1:0] amb,
                             input logic signed [VEL_W-1:0] vin, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(MAX_GAP, 0) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid             <= 1'b1;
        i_pot_temp          <= pt;
        i_vapour_ratio      <= qv;
        i_cloud_water       <= qc;
        i_cloud_water_below <= qcb;
        i_ambient_temp      <= amb;
        i_velocity_in       <= vin;
        do @(posedge i_clk); while (o_stall);
        pending_updates.push_back(predict_update(pt, qv, qc, qcb, amb, vin));
        cells_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random_cell(input bit gaps);
        logic [PT_W-1:0] pt, amb;
        int sel;
        pt  = PT_W'($urandom_range(32'h3FFFFF, 0));
        sel = $urandom_range(9, 0);
        // Mostly realistic temperatures near each other; sometimes a zero ambient, sometimes anything.
        if (sel < 6) begin
            pt  = PT_W'($urandom_range(32'd1400000, 32'd900000));
            amb = PT_W'(pt + $urandom_range(8000, 0) - 4000);
        end else if (sel == 6) begin
            amb = '0;
        end else begin
            amb = PT_W'($urandom_range(32'h3FFFFF, 1));
        end
        send_cell(pt, Q_W'($urandom), Q_W'($urandom), Q_W'($urandom), amb,
                  VEL_W'($urandom), gaps);
    endtask

    // Hold off until every expected update is back, then let the pipe drain.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_updates.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_gain(input logic [CFG_IDX_W-1:0] idx,
                              input logic [GAIN_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_BUOY_GAIN) buoy_gain = value;
        else if (idx == REG_GRAV_GAIN) grav_gain = value;
    endtask

    // Directed cells: field extremes, zero divisor and both saturation limits.
    task automatic test_directed();
        send_cell('0, '0, '0, '0, '0, '0, 1'b0);
        send_cell('1, '1, '1, '1, '0, 32'sh7FFFFFFF, 1'b0);
        send_cell(22'd1228800, 16'd655, 16'd0, 16'd0, 22'd1228800, 32'sd0, 1'b0);
        send_cell(22'd1232896, 16'd1000, 16'd100, 16'd200, 22'd1228800, 32'sd65536, 1'b0);
        send_cell(22'd1224704, 16'd1000, 16'd100, 16'd200, 22'd1228800, -32'sd65536, 1'b0);
        send_cell('1, '1, '0, '0, 22'd1, 32'sh7FFFFFFF, 1'b0);
        send_cell('1, '0, '0, '0, 22'd1, 32'sh7FFFFF00, 1'b0);
        send_cell('0, '1, '1, '1, '1, 32'sh80000000, 1'b0);
        send_cell('0, '0, '1, '1, 22'd1, 32'sh80000010, 1'b0);
        send_cell(22'd1, 16'd1, 16'd1, 16'd1, '1, 32'sd1, 1'b0);
        send_cell('1, '1, '1, '1, '1, -32'sd1, 1'b0);
        send_cell(22'h2AAAAA, 16'h5555, 16'hAAAA, 16'h5555, 22'h155555, 32'sh55555555, 1'b0);
        send_cell(22'h155555, 16'hAAAA, 16'h5555, 16'hAAAA, 22'h2AAAAA, 32'shAAAAAAAA, 1'b0);
    endtask

    // Random cells under one gain setting, with optional gaps and output stalls.
    task automatic test_random(input int count, input bit gaps);
        repeat (count) send_random_cell(gaps);
    endtask

    // Step through gain settings, extremes included; drain before each round of writes.
    task automatic test_gain_sweep();
        logic [GAIN_W-1:0] bg[5] = '{24'd0, 24'hFFFFFF, 24'd65536, 24'd1, 24'd300000};
        logic [GAIN_W-1:0] gg[5] = '{24'hFFFFFF, 24'd0, 24'd642908, 24'd1, 24'd123456};
        for (int k = 0; k < 5; k++) begin
            wait_drained();
            write_gain(REG_BUOY_GAIN, bg[k]);
            write_gain(REG_GRAV_GAIN, gg[k]);
            // An unknown register index must leave both gains alone.
            write_gain(REG_SPARE_A, GAIN_W'($urandom));
            write_gain(REG_SPARE_B, GAIN_W'($urandom));
            test_directed();
            test_random(130, 1'b1);
        end
        wait_drained();
        write_gain(REG_BUOY_GAIN, GAIN_W'($urandom));
        write_gain(REG_GRAV_GAIN, GAIN_W'($urandom));
        // Back-to-back burst with no sender gaps.
        test_random(120, 1'b0);
    endtask

    // Output side: draw a stall length for each result as it appears, hold
    // stall for that many cycles, then release it until the result is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall     <= 1'b0;
            stall_wait  = 0;
            stall_drawn = 1'b0;
        end else begin
            if (stall_drawn && !i_stall) stall_drawn = 1'b0;
            if (o_valid && !stall_drawn) begin
                stall_wait  = output_stalls_on ? $urandom_range(MAX_GAP, 0) : 0;
                stall_drawn = 1'b1;
            end
            if (stall_wait > 0) begin
                i_stall <= 1'b1;
                stall_wait--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: watchdog expired, %0d updates outstanding", $time,
                         pending_updates.size());
                $display("cloud_buoyancy_velocity_update test failed");
                $finish;
            end
        end
    end

    // Compare each accepted update with the oldest prediction.
    always @(posedge i_clk) begin
        t_update want;
        if (i_rst_n && o_valid && !i_stall) begin
            updates_seen++;
            if (pending_updates.size() == 0) begin
                $display("%0t: unexpected update, actual velocity %0d", $time,
                         o_velocity_out);
                error_count++;
            end else begin
                want = pending_updates.pop_front();
                if (want.zero_div) zero_div_seen++;
                if (want.sat) sat_seen++;
                if (o_velocity_out !== want.velocity) begin
                    $display("%0t: velocity expected %0d actual %0d", $time,
                             want.velocity, o_velocity_out);
                    error_count++;
                end
                if (o_zero_divisor !== want.zero_div) begin
                    $display("%0t: zero_divisor expected %0b actual %0b", $time,
                             want.zero_div, o_zero_divisor);
                    error_count++;
                end
                if (o_saturated !== want.sat) begin
                    $display("%0t: saturated expected %0b actual %0b", $time,
                             want.sat, o_saturated);
                    error_count++;
                end
            end
        end
    end

    initial begin
        cells_sent = 0;
        output_stalls_on = 1'b0;
        buoy_gain = BUOY_RESET;
        grav_gain = GRAV_RESET;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        i_valid = 1'b0;
        i_pot_temp = '0; i_vapour_ratio = '0; i_cloud_water = '0;
        i_cloud_water_below = '0; i_ambient_temp = '0; i_velocity_in = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset gains first, with a clean output side.
        test_directed();
        output_stalls_on = 1'b1;
        test_random(80, 1'b1);
        test_gain_sweep();
        wait_drained();

        $display("Covered %0d cells, %0d updates checked, %0d zero divisor, %0d saturated.",
                 cells_sent, updates_seen, zero_div_seen, sat_seen);
        if (error_count == 0 && pending_updates.size() == 0)
            $display("cloud_buoyancy_velocity_update test passed");
        else
            $display("cloud_buoyancy_velocity_update test failed");
        $finish;
    end

endmodule
